// ===== hdl/fnet_pkg.sv =====
package fnet_pkg;

  localparam int FRAME_SIDE = 256;
  localparam int PIX_W      = 8;
  localparam int OUT_W      = 8;
  localparam int COORD_W    = (FRAME_SIDE > 1) ? $clog2(FRAME_SIDE) : 1;
  localparam int NUM_BUFS   = 3;
  localparam int MAX_RES    = 3;
  localparam int STORE_DEPTH = NUM_BUFS * FRAME_SIDE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  typedef logic [PIX_W-1:0]    pix_t;
  typedef logic [COORD_W-1:0]  coord_t;
  typedef logic [1:0]          buf_sel_t;
  typedef logic [1:0]          res_cnt_t;
  typedef logic [STORE_AW-1:0] store_addr_t;

  localparam coord_t LAST_IDX     = COORD_W'(FRAME_SIDE - 1);
  localparam pix_t   EDGE_VAL     = 8'd0;
  localparam pix_t   FLAT_VAL     = 8'd255;
  localparam pix_t   THRESH_RESET = 8'd30;

  typedef struct packed {
    logic [OUT_W-1:0] row;
    logic [OUT_W-1:0] col;
    pix_t             pixel;
    logic             done;
  } res_t;

  // results of one pixel transaction, handed to the output queue
  typedef struct packed {
    logic                   load;
    res_cnt_t               n;
    res_t [MAX_RES-1:0]     slot;
  } res_load_t;

  // access of the row buffers for one accepted pixel
  typedef struct packed {
    logic     en;
    buf_sel_t sel;
    coord_t   col;
    logic     at_last;
    pix_t     wr_data;
  } line_ctl_t;

  function automatic buf_sel_t sel_prev(input buf_sel_t s);
    return (s == 2'd0) ? buf_sel_t'(NUM_BUFS - 1) : s - 2'd1;
  endfunction

  function automatic buf_sel_t sel_next(input buf_sel_t s);
    return (s == buf_sel_t'(NUM_BUFS - 1)) ? 2'd0 : s + 2'd1;
  endfunction

endpackage

// ===== hdl/fnet_pix_if.sv =====
interface fnet_pix_if;
  logic                      valid;
  logic                      ready;
  logic [fnet_pkg::PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== hdl/fnet_res_if.sv =====
interface fnet_res_if;
  logic                       valid;
  logic                       ready;
  logic [fnet_pkg::OUT_W-1:0] out_row;
  logic [fnet_pkg::OUT_W-1:0] out_col;
  logic [fnet_pkg::PIX_W-1:0] out_pixel;
  logic                       frame_done;

  modport source (output valid, output out_row, output out_col, output out_pixel,
                  output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_pixel,
                  input frame_done, output ready);
endinterface

// ===== hdl/four_neighbour_edge_threshold_top.sv =====
// Each pixel goes through stage s1 into the result queue: result (r,c) comes from pixel
// (r+1,c), on the last row also from (r,c+1), and the final result from the final pixel.
// Throughput: one pixel per clock while res.ready is high, no results on row 0; the last
// row gives two results per pixel past the first (three on the final), so the input stalls.
// Reset (rst, synchronous) clears the counters, pipeline and queue and sets the threshold
// to 30; the row buffer RAMs are not cleared, and no value read before it is written is used.
module four_neighbour_edge_threshold_top (
  input  logic             clk,
  input  logic             rst,
  fnet_pix_if.sink         pix,
  fnet_res_if.source       res,
  input  logic             cfg_wr_en,
  input  fnet_pkg::pix_t   cfg_wr_data
);

  fnet_pkg::pix_t      threshold;
  fnet_pkg::coord_t    row;
  fnet_pkg::coord_t    col;
  fnet_pkg::buf_sel_t  sel;
  logic                accept;
  logic                at_last;

  logic                s1_valid;
  fnet_pkg::coord_t    s1_row;
  fnet_pkg::coord_t    s1_col;
  fnet_pkg::pix_t      s1_px;
  logic                s1_take;

  fnet_pkg::pix_t      win_l;
  fnet_pkg::pix_t      win_c;
  fnet_pkg::pix_t      prev0;
  fnet_pkg::pix_t      prev1;
  fnet_pkg::pix_t      rd_a;
  fnet_pkg::pix_t      rd_b;

  fnet_pkg::line_ctl_t ctl;
  fnet_pkg::res_load_t ld;
  logic                can_load;

  logic                last_row;
  logic                edge_main;
  logic                edge_left;
  logic                edge_fin;

  function automatic logic exceeds(input fnet_pkg::pix_t a, input fnet_pkg::pix_t b,
                                   input fnet_pkg::pix_t th);
    fnet_pkg::pix_t d;
    d = (a > b) ? (a - b) : (b - a);
    return d > th;
  endfunction

  // row 0 gives nothing; the last row adds its left neighbour and, at row end, itself
  function automatic fnet_pkg::res_cnt_t res_cnt_n(input fnet_pkg::coord_t r,
                                                   input fnet_pkg::coord_t c,
                                                   input logic             lr);
    fnet_pkg::res_cnt_t n;
    n = '0;
    if (r != '0) begin
      n = 2'd1;
    end
    if (lr && (c != '0)) begin
      n = 2'd2;
    end
    if (lr && (c == fnet_pkg::LAST_IDX)) begin
      n = 2'd3;
    end
    return n;
  endfunction

  assign pix.ready = !s1_valid || can_load;
  assign accept    = pix.valid && pix.ready;
  assign at_last   = (col == fnet_pkg::LAST_IDX);
  assign s1_take   = s1_valid && can_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fnet_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      threshold <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
      sel <= '0;
    end else if (accept) begin
      if (at_last) begin
        col <= '0;
        if (row == fnet_pkg::LAST_IDX) begin
          row <= '0;
          sel <= '0;
        end else begin
          row <= row + fnet_pkg::COORD_W'(1);
          sel <= fnet_pkg::sel_next(sel);
        end
      end else begin
        col <= col + fnet_pkg::COORD_W'(1);
      end
    end
  end

  assign ctl.en      = accept;
  assign ctl.sel     = sel;
  assign ctl.col     = col;
  assign ctl.at_last = at_last;
  assign ctl.wr_data = pix.pixel_in;

  fnet_line_store u_line_store (
    .clk  (clk),
    .ctl  (ctl),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_row <= row;
      s1_col <= col;
      s1_px  <= pix.pixel_in;
    end
  end

  // slide the window over the row above and keep the last two pixels of this row
  always_ff @(posedge clk) begin
    if (s1_take) begin
      win_l <= win_c;
      win_c <= rd_a;
      prev1 <= prev0;
      prev0 <= s1_px;
    end
  end

  assign last_row = (s1_row == fnet_pkg::LAST_IDX);

  always_comb begin
    edge_main = exceeds(win_c, s1_px, threshold)
             || ((s1_row >= fnet_pkg::COORD_W'(2)) && exceeds(win_c, rd_b, threshold))
             || ((s1_col != '0) && exceeds(win_c, win_l, threshold))
             || ((s1_col != fnet_pkg::LAST_IDX) && exceeds(win_c, rd_a, threshold));
    edge_left = exceeds(prev0, win_l, threshold)
             || exceeds(prev0, s1_px, threshold)
             || ((s1_col >= fnet_pkg::COORD_W'(2)) && exceeds(prev0, prev1, threshold));
    edge_fin  = exceeds(s1_px, win_c, threshold) || exceeds(s1_px, prev0, threshold);
  end

  always_comb begin
    ld.load = s1_take;
    ld.n    = res_cnt_n(s1_row, s1_col, last_row);

    ld.slot[0].row   = fnet_pkg::OUT_W'(s1_row - fnet_pkg::COORD_W'(1));
    ld.slot[0].col   = fnet_pkg::OUT_W'(s1_col);
    ld.slot[0].pixel = edge_main ? fnet_pkg::EDGE_VAL : fnet_pkg::FLAT_VAL;
    ld.slot[0].done  = 1'b0;

    ld.slot[1].row   = fnet_pkg::OUT_W'(s1_row);
    ld.slot[1].col   = fnet_pkg::OUT_W'(s1_col - fnet_pkg::COORD_W'(1));
    ld.slot[1].pixel = edge_left ? fnet_pkg::EDGE_VAL : fnet_pkg::FLAT_VAL;
    ld.slot[1].done  = 1'b0;

    ld.slot[2].row   = fnet_pkg::OUT_W'(s1_row);
    ld.slot[2].col   = fnet_pkg::OUT_W'(s1_col);
    ld.slot[2].pixel = edge_fin ? fnet_pkg::EDGE_VAL : fnet_pkg::FLAT_VAL;
    ld.slot[2].done  = 1'b1;
  end

  fnet_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .ld       (ld),
    .can_load (can_load),
    .res      (res)
  );

endmodule

// ===== hdl/fnet_ram.sv =====
module fnet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/fnet_line_store.sv =====
module fnet_line_store (
  input  logic                clk,
  input  fnet_pkg::line_ctl_t ctl,
  output fnet_pkg::pix_t      rd_a,
  output fnet_pkg::pix_t      rd_b
);

  fnet_pkg::store_addr_t wr_addr;
  fnet_pkg::store_addr_t a_addr;
  fnet_pkg::store_addr_t b_addr;

  function automatic fnet_pkg::store_addr_t row_addr(input fnet_pkg::buf_sel_t s,
                                                     input fnet_pkg::coord_t   c);
    return fnet_pkg::store_addr_t'(s) * fnet_pkg::store_addr_t'(fnet_pkg::FRAME_SIDE)
         + fnet_pkg::store_addr_t'(c);
  endfunction

  assign wr_addr = row_addr(ctl.sel, ctl.col);

  // port A: row above at the next column, or start of the current row at row end
  assign a_addr = ctl.at_last ? row_addr(ctl.sel, '0)
                              : row_addr(fnet_pkg::sel_prev(ctl.sel),
                                         ctl.col + fnet_pkg::COORD_W'(1));
  // port B: two rows above at the current column
  assign b_addr = row_addr(fnet_pkg::sel_next(ctl.sel), ctl.col);

  // keep two copies of the three rows, one per read port
  fnet_ram #(
    .WIDTH (fnet_pkg::PIX_W),
    .DEPTH (fnet_pkg::STORE_DEPTH)
  ) u_ram_a (
    .clk     (clk),
    .wr_en   (ctl.en),
    .wr_addr (wr_addr),
    .wr_data (ctl.wr_data),
    .rd_en   (ctl.en),
    .rd_addr (a_addr),
    .rd_data (rd_a)
  );

  fnet_ram #(
    .WIDTH (fnet_pkg::PIX_W),
    .DEPTH (fnet_pkg::STORE_DEPTH)
  ) u_ram_b (
    .clk     (clk),
    .wr_en   (ctl.en),
    .wr_addr (wr_addr),
    .wr_data (ctl.wr_data),
    .rd_en   (ctl.en),
    .rd_addr (b_addr),
    .rd_data (rd_b)
  );

endmodule

// ===== hdl/fnet_res_queue.sv =====
module fnet_res_queue (
  input  logic                clk,
  input  logic                rst,
  input  fnet_pkg::res_load_t ld,
  output logic                can_load,
  fnet_res_if.source          res
);

  fnet_pkg::res_t   q [fnet_pkg::MAX_RES];
  fnet_pkg::res_cnt_t cnt;
  logic             pop;

  assign res.valid      = (cnt != 2'd0);
  assign res.out_row    = q[0].row;
  assign res.out_col    = q[0].col;
  assign res.out_pixel  = q[0].pixel;
  assign res.frame_done = q[0].done;

  assign pop      = res.valid && res.ready;
  assign can_load = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ld.load) begin
      cnt <= ld.n;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  // payload: load the new set, otherwise shift towards the head on a transaction
  always_ff @(posedge clk) begin
    if (ld.load) begin
      for (int i = 0; i < fnet_pkg::MAX_RES; i++) begin
        q[i] <= ld.slot[i];
      end
    end else if (pop) begin
      for (int i = 0; i < fnet_pkg::MAX_RES - 1; i++) begin
        q[i] <= q[i+1];
      end
    end
  end

endmodule
